[rtl/suks_pkg.sv]
package suks_pkg;

	// Set capacity and the widths that follow from it
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths
	localparam int KEY_W    = 32;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_SEARCH = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 3'd0,
		STAT_DUPLICATE = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_FOUND     = 3'd3,
		STAT_NOT_FOUND = 3'd4,
		STAT_CLEARED   = 3'd5
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EVAL = 1'b1
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

[rtl/suks_ctrl.sv]
module suks_ctrl
	import suks_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output logic    done,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EVAL: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.exec;
		end
	end

	assign done = done_q;

endmodule

[rtl/suks_datapath.sv]
module suks_datapath
	import suks_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	input  logic [ACTION_W-1:0]        action_in,
	input  logic signed [KEY_W-1:0]    key_in,
	output logic [STATUS_W-1:0]        status,
	output logic [POS_W-1:0]           position,
	output logic [COUNT_W-1:0]         count
);

	// Row of key cells, ascending; only cells below count_q hold keys
	logic signed [KEY_W-1:0] cells_q [CAPACITY];
	logic [CNT_W-1:0]        count_q;

	logic signed [KEY_W-1:0] key_q;
	action_t                 action_q;

	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic [CNT_W-1:0]    lb;
	logic                hit;
	logic                full;
	logic                ins_en;
	logic                clr_en;
	status_t             res_status;
	logic [CNT_W-1:0]    res_pos;
	logic [CNT_W-1:0]    count_d;

	status_t             status_q;
	logic [POS_W-1:0]    position_q;
	logic [COUNT_W-1:0]  count_res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q    <= key_in;
			action_q <= action_t'(action_in);
		end
	end

	// Compare every held key against the probe in parallel
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt[i] = (CNT_W'(i) < count_q) && (cells_q[i] < key_q);
			eq[i] = (CNT_W'(i) < count_q) && (cells_q[i] == key_q);
		end
	end

	// Lower bound: first cell not below the probe, else count
	always_comb begin
		lb = count_q;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!lt[i]) begin
				lb = CNT_W'(i);
			end
		end
	end

	always_comb begin
		hit        = |eq;
		full       = (count_q == CNT_W'(CAPACITY));
		ins_en     = 1'b0;
		clr_en     = 1'b0;
		res_pos    = '0;
		res_status = STAT_NOT_FOUND;
		case (action_q)
			ACT_INSERT: begin
				if (hit) begin
					res_status = STAT_DUPLICATE;
				end else if (full) begin
					res_status = STAT_FULL;
				end else begin
					res_status = STAT_INSERTED;
					res_pos    = lb;
					ins_en     = 1'b1;
				end
			end
			ACT_CLEAR: begin
				res_status = STAT_CLEARED;
				clr_en     = 1'b1;
			end
			default: begin
				if (hit) begin
					res_status = STAT_FOUND;
					res_pos    = lb;
				end
			end
		endcase
		count_d = count_q;
		if (clr_en) begin
			count_d = '0;
		end else if (ins_en) begin
			count_d = count_q + CNT_W'(1);
		end
	end

	// Shift the larger keys up one place and drop the new key in
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (cmd.exec && ins_en && lb == '0) begin
					cells_q[g] <= key_q;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk) begin
				if (cmd.exec && ins_en) begin
					if (lb == CNT_W'(g)) begin
						cells_q[g] <= key_q;
					end else if (lb < CNT_W'(g)) begin
						cells_q[g] <= cells_q[g-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q    <= res_status;
			position_q  <= POS_W'(res_pos);
			count_res_q <= COUNT_W'(count_d);
		end
	end

	assign status   = status_q;
	assign position = position_q;
	assign count    = count_res_q;

endmodule

[rtl/sorted_unique_key_set_top.sv]
// Sorted unique key set: insert, search and clear on up to CAPACITY signed keys.
// The request is registered at acceptance; the result registers and the
// strobe (done) load at the end of the evaluation, and the result transfers
// while done is high. The compare-and-shift pass over the row of key cells
// runs in the cycle after acceptance, with busy high; no request is taken then.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous) empties the set and returns to idle.
module sorted_unique_key_set_top
	import suks_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [ACTION_W-1:0]      action,
	input  logic signed [KEY_W-1:0]  key,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [POS_W-1:0]         position,
	output logic [COUNT_W-1:0]       count
);

	// Commands from the controller: load captures the request on a transfer,
	// exec runs the compare, updates the cells and registers the result.
	dp_cmd_t cmd;

	// Controller: idle until a transfer, then a single evaluation state; the
	// strobe follows the evaluation by one register.
	suks_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Datapath: key cells, entry count, parallel comparators, lower-bound
	// encoder and the result registers that drive the output ports.
	suks_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.action_in (action),
		.key_in    (key),
		.status    (status),
		.position  (position),
		.count     (count)
	);

endmodule

[rtl/suks_checker.sv]
module suks_checker
	import suks_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [ACTION_W-1:0]      action,
	input  logic signed [KEY_W-1:0]  key,
	input  logic                     done,
	input  logic [STATUS_W-1:0]      status,
	input  logic [POS_W-1:0]         position,
	input  logic [COUNT_W-1:0]       count
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after transfer");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result strobe missing two cycles after transfer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("strobe without preceding evaluation");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_CLEARED |-> count == '0)
		else $error("clear left keys");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STAT_DUPLICATE || status == STAT_FULL ||
		status == STAT_NOT_FOUND || status == STAT_CLEARED) |-> position == '0)
		else $error("position set on a miss");

endmodule

bind sorted_unique_key_set_top suks_checker u_suks_checker (.*);

[dv/testbench.sv]
module testbench;
	import suks_pkg::*;

	// Action code left unused by the block; it must behave as a search
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	localparam int POOL_SIZE    = 24;
	localparam int PHASE_ITEMS  = 106;
	localparam int MAX_GAP      = 12;
	localparam int DRAIN_LIMIT  = 1000;
	localparam int SETTLE_TICKS = 10;

	typedef struct {
		status_t              status;
		logic [POS_W-1:0]     position;
		logic [COUNT_W-1:0]   count;
	} set_reply_t;

	// Shadow of the key set: predicts each reply from the requests that the
	// block accepts and matches the replies against them in order.
	class key_set_scoreboard;
		logic signed [KEY_W-1:0] held_keys[CAPACITY];
		int unsigned             held_count;
		set_reply_t              pending_replies[$];
		int unsigned             mismatches;
		int unsigned             status_hits[8];
		int unsigned             transfers;

		function void note_request(logic [ACTION_W-1:0] act, logic signed [KEY_W-1:0] probe);
			set_reply_t  r;
			int unsigned slot;
			bit          hit;
			r.position = '0;
			if (act == ACT_CLEAR) begin
				held_count = 0;
				r.status = STAT_CLEARED;
			end else begin
				// lower bound: first held key not below the probe (signed order)
				slot = 0;
				while (slot < held_count && held_keys[slot] < probe)
					slot++;
				hit = (slot < held_count) && (held_keys[slot] == probe);
				if (act == ACT_INSERT) begin
					// duplicate check comes before the full check
					if (hit) begin
						r.status = STAT_DUPLICATE;
					end else if (held_count >= CAPACITY) begin
						r.status = STAT_FULL;
					end else begin
						for (int unsigned j = held_count; j > slot; j--)
							held_keys[j] = held_keys[j - 1];
						held_keys[slot] = probe;
						held_count++;
						r.status = STAT_INSERTED;
						r.position = slot[POS_W-1:0];
					end
				end else begin
					// search, and the spare code which acts as one
					if (hit) begin
						r.status = STAT_FOUND;
						r.position = slot[POS_W-1:0];
					end else begin
						r.status = STAT_NOT_FOUND;
					end
				end
			end
			r.count = held_count[COUNT_W-1:0];
			status_hits[r.status]++;
			transfers++;
			pending_replies.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [POS_W-1:0] pos,
				logic [COUNT_W-1:0] cnt);
			set_reply_t want;
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply status %0d position %0d count %0d",
					$time, st, pos, cnt);
				mismatches++;
				return;
			end
			want = pending_replies.pop_front();
			if (st !== want.status) begin
				$display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, st);
				mismatches++;
			end
			if (pos !== want.position) begin
				$display("%0t: position mismatch, expected %0d, got %0d",
					$time, want.position, pos);
				mismatches++;
			end
			if (cnt !== want.count) begin
				$display("%0t: count mismatch, expected %0d, got %0d", $time, want.count, cnt);
				mismatches++;
			end
		endfunction
	endclass

	logic                     clk    = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start  = 1'b0;
	logic [ACTION_W-1:0]      action = ACT_SEARCH;
	logic signed [KEY_W-1:0]  key    = '0;
	logic                     busy;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic [POS_W-1:0]         position;
	logic [COUNT_W-1:0]       count;

	key_set_scoreboard sb = new();

	// Percentage of cycles in which the sender holds back between transfers
	int unsigned sender_idle_pct = 0;

	sorted_unique_key_set_top dut (.*);

	always #5 clk = ~clk;

	// Watch both sides at each rising edge. Values read here are the ones
	// held during the cycle that this edge ends, so the order of events in
	// the time step does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(action, key);
			// the receiver cannot hold results off: every strobe is a transfer
			if (done)
				sb.check_result(status, position, count);
		end
	end

	// Present one request and hold it until the block takes it, then idle the
	// sender for a random stretch. With no gap, start simply stays high for
	// the next request so that it is never lowered and raised in one step.
	task automatic issue_request(logic [ACTION_W-1:0] act, logic signed [KEY_W-1:0] probe);
		int unsigned gap;
		start  <= 1'b1;
		action <= act;
		key    <= probe;
		do @(posedge clk); while (busy);
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random traffic over a small pool of keys so that duplicates, hits and
	// a full set turn up often; clears are rare so that the set can fill.
	task automatic run_random_phase(int unsigned idle_pct);
		logic signed [KEY_W-1:0] pool[POOL_SIZE];
		logic [ACTION_W-1:0]     act;
		logic signed [KEY_W-1:0] probe;
		int unsigned             roll;
		sender_idle_pct = idle_pct;
		foreach (pool[i])
			pool[i] = $urandom;
		// keep the extremes and the values around zero in every pool
		pool[0] = KEY_MIN;
		pool[1] = KEY_MAX;
		pool[2] = '0;
		pool[3] = -1;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			roll = $urandom_range(99);
			if (roll < 55)
				act = ACT_INSERT;
			else if (roll < 94)
				act = ACT_SEARCH;
			else if (roll < 98)
				act = ACT_SPARE;
			else
				act = ACT_CLEAR;
			if ($urandom_range(3) == 0)
				probe = $urandom;
			else
				probe = pool[$urandom_range(POOL_SIZE - 1)];
			issue_request(act, probe);
		end
	endtask

	// Hard stop in case the block never answers or never drops busy
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int drain;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty set, extremes, duplicates, spare code, fill to
		// capacity, full rejection and a duplicate while full, then clear.
		issue_request(ACT_SEARCH, 32'sd5);
		issue_request(ACT_SPARE, KEY_MIN);
		issue_request(ACT_INSERT, KEY_MAX);
		issue_request(ACT_INSERT, KEY_MIN);
		issue_request(ACT_INSERT, 32'sd0);
		issue_request(ACT_INSERT, -32'sd1);
		issue_request(ACT_INSERT, 32'sd1);
		issue_request(ACT_INSERT, KEY_MIN);
		issue_request(ACT_SEARCH, KEY_MIN);
		issue_request(ACT_SEARCH, 32'sd2);
		issue_request(ACT_SPARE, KEY_MAX);
		for (int i = 1; i <= 11; i++)
			issue_request(ACT_INSERT, (i % 2) ? i * 1000 : -i * 1000);
		issue_request(ACT_INSERT, 32'sd7);
		issue_request(ACT_INSERT, KEY_MIN);
		issue_request(ACT_SEARCH, KEY_MAX);
		issue_request(ACT_CLEAR, KEY_MAX);

		// Random phases: back to back, sender mostly idle, back to back again
		// (a receiver stall cannot be applied), then light sender idling.
		run_random_phase(0);
		run_random_phase(58);
		run_random_phase(0);
		run_random_phase(25);
		start <= 1'b0;

		// Drain outstanding replies, then give the block time to show any
		// stray strobe before closing.
		drain = 0;
		while (sb.pending_replies.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_TICKS) @(posedge clk);
		if (sb.pending_replies.size() != 0) begin
			$display("%0t: %0d replies never arrived", $time, sb.pending_replies.size());
			sb.mismatches++;
		end

		$display("Run covered %0d transfers: %0d inserted, %0d duplicate, %0d full,",
			sb.transfers, sb.status_hits[STAT_INSERTED], sb.status_hits[STAT_DUPLICATE],
			sb.status_hits[STAT_FULL]);
		$display("  %0d found, %0d not found, %0d clears, %0d mismatches",
			sb.status_hits[STAT_FOUND], sb.status_hits[STAT_NOT_FOUND],
			sb.status_hits[STAT_CLEARED], sb.mismatches);
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
